@@ src/utf8_stream_decoder_assert.svh @@
// Assertion shorthands used by the checker of the UTF-8 decoder.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define UTF8D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/utf8d_pkg.sv @@
package utf8d_pkg;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_OUTPUT_MODE = 1'b0,
    CFG_MAX_UNITS   = 1'b1
  } cfg_idx_t;

  localparam logic [20:0] SURR_MASK = 21'h1FF800;
  localparam logic [20:0] SURR_BASE = 21'h00D800;
  localparam logic [20:0] HI_SURR   = 21'h00D800;
  localparam logic [20:0] LO_SURR   = 21'h00DC00;
  localparam logic [20:0] SUPP_BASE = 21'h010000;
  localparam logic [20:0] BMP_MAX   = 21'h00FFFF;
  localparam logic [20:0] CP_MAX    = 21'h10FFFF;
  localparam logic [20:0] BOM_CP    = 21'h00FEFF;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [20:0] unit_value;
    logic [15:0] byte_offset;
    logic        end_of_string;
    logic        bad_input;
    logic [15:0] unit_count;
  } result_t;

  // Up to three beats produced by one input byte, in order from slot 0
  typedef struct packed {
    logic [1:0]         n;
    result_t [2:0]      res;
  } push_t;

  function automatic logic [2:0] shortest_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp <= 21'h00007F)      len = 3'd1;
    else if (cp <= 21'h0007FF) len = 3'd2;
    else if (cp <= BMP_MAX)    len = 3'd3;
    else if (cp <= CP_MAX)     len = 3'd4;
    else                       len = 3'd0;
    return len;
  endfunction

endpackage

@@ src/utf8d_dec.sv @@
module utf8d_dec
  import utf8d_pkg::*;
#(
  parameter int unsigned MAX_STRING_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        output_mode,
  input  logic [15:0] max_units,
  output push_t       push
);

  localparam int unsigned CAP_FULL = MAX_STRING_BYTES - 1;
  localparam int unsigned CAP_INT  = (CAP_FULL > 65535) ? 65535 : CAP_FULL;
  localparam logic [15:0] OFFSET_CAP = 16'(CAP_INT);

  logic [20:0] pp_r, pp_nxt;
  logic [1:0]  bl_r, bl_nxt;
  logic [2:0]  sl_r, sl_nxt;
  logic [15:0] bc_r, bc_nxt;
  logic [15:0] cs_r, cs_nxt;
  logic [15:0] uw_r, uw_nxt;
  logic        err_r, err_nxt;
  logic        full_r, full_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r   <= '0;
      bl_r   <= '0;
      sl_r   <= '0;
      bc_r   <= '0;
      cs_r   <= '0;
      uw_r   <= '0;
      err_r  <= 1'b0;
      full_r <= 1'b0;
    end else begin
      pp_r   <= pp_nxt;
      bl_r   <= bl_nxt;
      sl_r   <= sl_nxt;
      bc_r   <= bc_nxt;
      cs_r   <= cs_nxt;
      uw_r   <= uw_nxt;
      err_r  <= err_nxt;
      full_r <= full_nxt;
    end
  end

  always_comb begin
    logic        done;
    logic        room;
    logic [20:0] v;
    logic [1:0]  n;
    pp_nxt   = pp_r;
    bl_nxt   = bl_r;
    sl_nxt   = sl_r;
    bc_nxt   = bc_r;
    cs_nxt   = cs_r;
    uw_nxt   = uw_r;
    err_nxt  = err_r;
    full_nxt = full_r;
    done     = 1'b0;
    n        = 2'd0;
    push     = '0;
    room     = (max_units < uw_r) || ((max_units - uw_r) > 16'd1);
    v        = pp_nxt - SUPP_BASE;
    if (step) begin
      if (!err_r && !full_r) begin
        if (bl_r == 2'd0) begin
          cs_nxt = bc_r;
          if (uw_r >= max_units) begin
            full_nxt = 1'b1;
          end else if (!data_byte[7]) begin
            pp_nxt = {13'd0, data_byte};
            sl_nxt = 3'd1;
            done   = 1'b1;
          end else if (data_byte[7:5] == 3'b110) begin
            pp_nxt = {16'd0, data_byte[4:0]};
            sl_nxt = 3'd2;
            bl_nxt = 2'd1;
          end else if (data_byte[7:4] == 4'b1110) begin
            pp_nxt = {17'd0, data_byte[3:0]};
            sl_nxt = 3'd3;
            bl_nxt = 2'd2;
          end else if (data_byte[7:3] == 5'b11110) begin
            pp_nxt = {18'd0, data_byte[2:0]};
            sl_nxt = 3'd4;
            bl_nxt = 2'd3;
          end else begin
            err_nxt = 1'b1;
          end
        end else if (data_byte[7:6] != 2'b10) begin
          err_nxt = 1'b1;
          bl_nxt  = 2'd0;
        end else begin
          pp_nxt = {pp_r[14:0], data_byte[5:0]};
          bl_nxt = bl_r - 2'd1;
          done   = (bl_r == 2'd1);
        end

        v = pp_nxt - SUPP_BASE;
        if (done) begin
          if (shortest_len(pp_nxt) != sl_nxt || (pp_nxt & SURR_MASK) == SURR_BASE) begin
            err_nxt = 1'b1;
          end else if (cs_nxt == 16'd0 && pp_nxt == BOM_CP) begin
            // leading byte-order mark is dropped
          end else if (!output_mode || pp_nxt <= BMP_MAX) begin
            push.res[0] = '{unit_value: pp_nxt, byte_offset: cs_nxt,
                            end_of_string: 1'b0, bad_input: 1'b0, unit_count: 16'd0};
            n      = 2'd1;
            uw_nxt = uw_r + 16'd1;
          end else if (room) begin
            push.res[0] = '{unit_value: HI_SURR | {11'd0, v[19:10]}, byte_offset: cs_nxt,
                            end_of_string: 1'b0, bad_input: 1'b0, unit_count: 16'd0};
            push.res[1] = '{unit_value: LO_SURR | {11'd0, v[9:0]}, byte_offset: cs_nxt,
                            end_of_string: 1'b0, bad_input: 1'b0, unit_count: 16'd0};
            n      = 2'd2;
            uw_nxt = uw_r + 16'd2;
          end else begin
            full_nxt = 1'b1;
          end
        end
      end

      if (bc_r < OFFSET_CAP) bc_nxt = bc_r + 16'd1;

      if (last_byte) begin
        // sequence cut off by the final byte
        if (bl_nxt != 2'd0 && !full_nxt) err_nxt = 1'b1;
        push.res[n] = '{unit_value: '0, byte_offset: '0, end_of_string: 1'b1,
                        bad_input: err_nxt, unit_count: uw_nxt};
        n        = n + 2'd1;
        pp_nxt   = '0;
        bl_nxt   = '0;
        sl_nxt   = '0;
        bc_nxt   = '0;
        cs_nxt   = '0;
        uw_nxt   = '0;
        err_nxt  = 1'b0;
        full_nxt = 1'b0;
      end
    end
    push.n = n;
  end

endmodule

@@ src/utf8d_queue.sv @@
module utf8d_queue
  import utf8d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  push_t            push,
  input  logic             pop,
  output result_t          head,
  output logic             not_empty,
  output logic [QUEUE_AW:0] count
);

  result_t               mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]     count_r, count_nxt;

  // multi-beat write: up to three consecutive slots per cycle
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push.n) mem_r[wr_ptr_r + QUEUE_AW'(i)] <= push.res[i];
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QUEUE_AW'(push.n);
    rd_ptr_nxt = rd_ptr_r + QUEUE_AW'(pop);
    count_nxt  = count_r + (QUEUE_AW + 1)'(push.n) - (QUEUE_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

@@ src/utf8_stream_decoder.sv @@
// UTF-8 stream decoder. Takes one byte per beat (in_tlast on the final byte of a string)
// and emits one beat per code point, or one or two UTF-16 units, each tagged with the
// offset of the character's first byte; the final byte also yields an end beat
// (out_tlast) with the unit count and, on out_tuser, whether the string was bad.
// Sustained rate is one byte per cycle while in_tready is high; a byte enters an input
// register, is decoded against the per-string state, and its up to three beats are
// written into an eight-entry output queue; the first result is then offered on out_tvalid
// from the head of that queue. in_tready is held low while more than two beats are
// queued; that queue depth and the downstream drain rate set the throughput. No
// clearing pass after reset. cfg writes take effect at once and belong between strings.
module utf8_stream_decoder
  import utf8d_pkg::*;
#(
  parameter int unsigned MAX_STRING_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [20:0] unit_value, [36:21] byte_offset,
                                  // [52:37] unit_count, [55:53] zero
  output logic        out_tlast,  // end_of_string
  output logic        out_tuser,  // bad_input
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic        output_mode_r;
  logic [15:0] max_units_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_mode_r <= 1'b0;
      max_units_r   <= 16'hFFFF;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_OUTPUT_MODE: output_mode_r <= cfg_wdata[0];
        CFG_MAX_UNITS:   max_units_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) in_vld_r <= 1'b0;
    else        in_vld_r <= in_tvalid && in_tready;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  push_t             push;
  result_t           head;
  logic              pop;
  logic [QUEUE_AW:0] q_count;

  utf8d_dec #(
    .MAX_STRING_BYTES (MAX_STRING_BYTES)
  ) u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_vld_r),
    .data_byte   (in_byte_r),
    .last_byte   (in_last_r),
    .output_mode (output_mode_r),
    .max_units   (max_units_r),
    .push        (push)
  );

  utf8d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (out_tvalid),
    .count     (q_count)
  );

  assign pop = out_tvalid && out_tready;

  // room for the byte in flight plus the one taken now, three beats each
  assign in_tready = (q_count <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 6));

  assign out_tdata = {3'd0, head.unit_count, head.byte_offset, head.unit_value};
  assign out_tlast = head.end_of_string;
  assign out_tuser = head.bad_input;

endmodule

@@ src/utf8d_checker.sv @@
`include "utf8_stream_decoder_assert.svh"

module utf8d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  `UTF8D_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled output beat changed")
  `UTF8D_ASSERT_NOW(a_unit_clean, out_tvalid && !out_tlast, !out_tuser && out_tdata[52:37] == 16'd0, "unit beat carries count or bad flag")
  `UTF8D_ASSERT_NOW(a_end_clean, out_tvalid && out_tlast, out_tdata[36:0] == 37'd0, "end beat carries value or offset")
  `UTF8D_ASSERT_NOW(a_value_range, out_tvalid, out_tdata[20:0] <= 21'h10FFFF && out_tdata[55:53] == 3'd0, "unit value out of range")

endmodule

bind utf8_stream_decoder utf8d_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
